>>> hw/rtl/msp_pkg.sv
// shared types, widths and constants of the motor speed pid block
package msp_pkg;

  localparam int STAMP_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int TARGET_W   = 16;
  localparam int DUTY_W     = 10;
  localparam int NUMER_W    = 24;
  localparam int SPEED_W    = 16;
  localparam int ANGLE_W    = 9;
  localparam int ERR_W      = 8;
  localparam int DERIV_W    = ERR_W + 1;
  localparam int INTEG_W    = 32;
  localparam int MUL_A_W    = GAIN_W + 1;
  localparam int MUL_B_W    = INTEG_W + 1;
  localparam int ACC_W      = MUL_A_W + MUL_B_W;
  localparam int DIVIDEND_W = NUMER_W;
  localparam int DIVISOR_W  = STAMP_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int SHIFT_BITS_DEF     = 22;
  localparam int EDGES_PER_TURN_DEF = 16;
  localparam int DEG_PER_TURN       = 360;

  localparam logic [GAIN_W-1:0]   GAIN_PROP_RST  = GAIN_W'(10000);
  localparam logic [GAIN_W-1:0]   GAIN_INTEG_RST = GAIN_W'(41000);
  localparam logic [GAIN_W-1:0]   GAIN_DERIV_RST = GAIN_W'(1);
  localparam logic [TARGET_W-1:0] TARGET_RST     = TARGET_W'(100);
  localparam logic [DUTY_W-1:0]   FLOOR_RST      = DUTY_W'(100);
  localparam logic [DUTY_W-1:0]   CEIL_RST       = DUTY_W'(900);
  localparam logic [NUMER_W-1:0]  NUMER_RST      = NUMER_W'(75000);

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEIL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR  = 3'd6;

  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic     cap_upd;
    logic     div_start;
    logic     spd_load;
    logic     err_load;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } status_t;

endpackage

>>> hw/rtl/msp_div.sv
// restoring divider, one quotient bit per cycle
module msp_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [msp_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [msp_pkg::DIVISOR_W-1:0]    divisor,
  output logic                             busy,
  output logic                             done,
  output logic [msp_pkg::DIVIDEND_W-1:0]   quotient
);

  localparam int W     = msp_pkg::DIVIDEND_W;
  localparam int DW    = msp_pkg::DIVISOR_W;
  localparam int CNT_W = $clog2(W);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [W-1:0]     quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    dvs_r;
  logic [DW:0]      shifted;
  logic [DW+1:0]    trial;
  logic             fits;
  logic             last;

  assign shifted = {rem_r, quo_r[W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = !trial[DW+1];
  assign last    = (cnt_r == CNT_W'(W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[W-2:0], fits};
      rem_r <= fits ? trial[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/msp_ctrl.sv
// sequencer for capture and control tick words, owns both handshakes
module msp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output msp_pkg::cmd_t    cmd,
  input  msp_pkg::status_t st
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPD_START,
    S_SPD_WAIT,
    S_ERR,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC_D,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   take;

  assign in_ready  = (state_r == S_IDLE);
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt         = state_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    cmd.cap_upd       = take && (in_cmd == msp_pkg::CMD_CAPTURE);
    cmd.div_start     = 1'b0;
    cmd.spd_load      = 1'b0;
    cmd.err_load      = 1'b0;
    cmd.mul_en        = 1'b0;
    cmd.mul_sel       = msp_pkg::MUL_P;
    cmd.acc_op        = msp_pkg::ACC_HOLD;
    cmd.out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (take && (in_cmd == msp_pkg::CMD_TICK)) begin
          state_nxt = S_SPD_START;
        end
      end
      S_SPD_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_SPD_WAIT;
      end
      S_SPD_WAIT: begin
        if (st.div_done) begin
          cmd.spd_load = 1'b1;
          state_nxt    = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err_load = 1'b1;
        state_nxt    = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = msp_pkg::MUL_P;
        state_nxt   = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = msp_pkg::MUL_I;
        cmd.acc_op  = msp_pkg::ACC_LOAD;
        state_nxt   = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = msp_pkg::MUL_D;
        cmd.acc_op  = msp_pkg::ACC_ADD;
        state_nxt   = S_ACC_D;
      end
      S_ACC_D: begin
        cmd.acc_op = msp_pkg::ACC_ADD;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == S_SPD_WAIT))
    else $error("divider finished outside the wait state");

  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !st.div_busy)
    else $error("input ready while divider busy");

  a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result word raised outside the output step");

endmodule

>>> hw/rtl/msp_dp.sv
// datapath: config registers, period capture, divider, pid arithmetic, output registers
module msp_dp #(
  parameter int SHIFT_BITS     = msp_pkg::SHIFT_BITS_DEF,
  parameter int EDGES_PER_TURN = msp_pkg::EDGES_PER_TURN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [msp_pkg::STAMP_W-1:0]     in_capture_time,
  input  msp_pkg::cmd_t                   cmd,
  output msp_pkg::status_t                st,
  output logic [msp_pkg::DUTY_W-1:0]      out_duty,
  output logic [msp_pkg::SPEED_W-1:0]     out_speed,
  output logic [msp_pkg::ANGLE_W-1:0]     out_angle
);

  localparam int CNT_W   = $clog2(EDGES_PER_TURN + 1);
  localparam int GAIN_W  = msp_pkg::GAIN_W;
  localparam int DUTY_W  = msp_pkg::DUTY_W;
  localparam int ERR_W   = msp_pkg::ERR_W;
  localparam int DERIV_W = msp_pkg::DERIV_W;
  localparam int INTEG_W = msp_pkg::INTEG_W;
  localparam int ACC_W   = msp_pkg::ACC_W;
  localparam int MUL_A_W = msp_pkg::MUL_A_W;
  localparam int MUL_B_W = msp_pkg::MUL_B_W;
  localparam int DVD_W   = msp_pkg::DIVIDEND_W;
  localparam int SPEED_W = msp_pkg::SPEED_W;
  localparam int ANGLE_W = msp_pkg::ANGLE_W;

  logic [GAIN_W-1:0]              gain_p_r;
  logic [GAIN_W-1:0]              gain_i_r;
  logic [GAIN_W-1:0]              gain_d_r;
  logic [msp_pkg::TARGET_W-1:0]   target_r;
  logic [DUTY_W-1:0]              floor_r;
  logic [DUTY_W-1:0]              ceil_r;
  logic [msp_pkg::NUMER_W-1:0]    numer_r;

  logic [msp_pkg::STAMP_W-1:0]    last_stamp_r;
  logic [msp_pkg::STAMP_W-1:0]    period_r;
  logic [CNT_W-1:0]               edge_cnt_r;
  logic [CNT_W-1:0]               edge_cnt_nxt;
  logic [ANGLE_W-1:0]             angle_r;
  logic signed [ERR_W-1:0]        prev_err_r;
  logic signed [INTEG_W-1:0]      integ_r;

  logic [SPEED_W-1:0]             speed_r;
  logic signed [ERR_W-1:0]        err_r;
  logic signed [DERIV_W-1:0]      deriv_r;
  logic signed [ACC_W-1:0]        prod_r;
  logic signed [ACC_W-1:0]        acc_r;

  logic [DUTY_W-1:0]              out_duty_r;
  logic [SPEED_W-1:0]             out_speed_r;
  logic [ANGLE_W-1:0]             out_angle_r;

  logic [ANGLE_W-1:0]             angle_tab [EDGES_PER_TURN+1];
  logic [DVD_W-1:0]               div_quo;
  logic [SPEED_W-1:0]             speed_nxt;
  logic [SPEED_W-1:0]             speed_diff;
  logic signed [ERR_W-1:0]        err_nxt;
  logic signed [DERIV_W-1:0]      deriv_nxt;
  logic signed [INTEG_W:0]        integ_sum;
  logic signed [INTEG_W-1:0]      integ_nxt;
  logic signed [MUL_A_W-1:0]      mul_a;
  logic signed [MUL_B_W-1:0]      mul_b;
  logic [ACC_W-1:0]               drive;
  logic [DUTY_W-1:0]              duty_nxt;

  genvar g;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= msp_pkg::GAIN_PROP_RST;
      gain_i_r <= msp_pkg::GAIN_INTEG_RST;
      gain_d_r <= msp_pkg::GAIN_DERIV_RST;
      target_r <= msp_pkg::TARGET_RST;
      floor_r  <= msp_pkg::FLOOR_RST;
      ceil_r   <= msp_pkg::CEIL_RST;
      numer_r  <= msp_pkg::NUMER_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        msp_pkg::REG_GAIN_PROP:  gain_p_r <= cfg_data[GAIN_W-1:0];
        msp_pkg::REG_GAIN_INTEG: gain_i_r <= cfg_data[GAIN_W-1:0];
        msp_pkg::REG_GAIN_DERIV: gain_d_r <= cfg_data[GAIN_W-1:0];
        msp_pkg::REG_TARGET:     target_r <= cfg_data[msp_pkg::TARGET_W-1:0];
        msp_pkg::REG_DUTY_FLOOR: floor_r  <= cfg_data[DUTY_W-1:0];
        msp_pkg::REG_DUTY_CEIL:  ceil_r   <= cfg_data[DUTY_W-1:0];
        msp_pkg::REG_NUMERATOR:  numer_r  <= cfg_data[msp_pkg::NUMER_W-1:0];
        default: ;
      endcase
    end
  end

  // angle of each edge count, fixed at elaboration
  for (g = 0; g <= EDGES_PER_TURN; g++) begin : g_angle
    assign angle_tab[g] = ANGLE_W'(g * msp_pkg::DEG_PER_TURN / EDGES_PER_TURN);
  end

  // edge capture and speed divider
  assign edge_cnt_nxt = (edge_cnt_r == CNT_W'(EDGES_PER_TURN)) ? '0 : edge_cnt_r + CNT_W'(1);

  msp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (numer_r),
    .divisor  (period_r),
    .busy     (st.div_busy),
    .done     (st.div_done),
    .quotient (div_quo)
  );

  // zero period divides to all ones and saturates as well
  assign speed_nxt = (|div_quo[DVD_W-1:SPEED_W]) ? msp_pkg::SPEED_MAX : div_quo[SPEED_W-1:0];

  // error, integral, derivative
  assign speed_diff = target_r - speed_r;
  assign err_nxt    = signed'(speed_diff[ERR_W-1:0]);
  assign deriv_nxt  = DERIV_W'(err_nxt) - DERIV_W'(prev_err_r);
  assign integ_sum  = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(err_nxt);

  always_comb begin
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_nxt = integ_sum[INTEG_W] ? msp_pkg::INTEG_MIN : msp_pkg::INTEG_MAX;
    end else begin
      integ_nxt = integ_sum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
      period_r     <= '0;
      edge_cnt_r   <= '0;
      angle_r      <= '0;
      prev_err_r   <= '0;
      integ_r      <= '0;
    end else begin
      if (cmd.cap_upd) begin
        period_r     <= in_capture_time - last_stamp_r;
        last_stamp_r <= in_capture_time;
        edge_cnt_r   <= edge_cnt_nxt;
        angle_r      <= angle_tab[edge_cnt_nxt];
      end
      if (cmd.err_load) begin
        prev_err_r <= err_nxt;
        integ_r    <= integ_nxt;
      end
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      msp_pkg::MUL_P: begin
        mul_a = signed'({1'b0, gain_p_r});
        mul_b = MUL_B_W'(err_r);
      end
      msp_pkg::MUL_I: begin
        mul_a = signed'({1'b0, gain_i_r});
        mul_b = MUL_B_W'(integ_r);
      end
      default: begin
        mul_a = signed'({1'b0, gain_d_r});
        mul_b = MUL_B_W'(deriv_r);
      end
    endcase
  end

  // clamp of the scaled drive
  assign drive = $unsigned(acc_r) >> SHIFT_BITS;

  always_comb begin
    if (acc_r[ACC_W-1]) begin
      duty_nxt = floor_r;
    end else if (drive < ACC_W'(floor_r)) begin
      duty_nxt = floor_r;
    end else if (drive > ACC_W'(ceil_r)) begin
      duty_nxt = ceil_r;
    end else begin
      duty_nxt = drive[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.spd_load) begin
      speed_r <= speed_nxt;
    end
    if (cmd.err_load) begin
      err_r   <= err_nxt;
      deriv_r <= deriv_nxt;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (cmd.acc_op)
      msp_pkg::ACC_LOAD: acc_r <= prod_r;
      msp_pkg::ACC_ADD:  acc_r <= acc_r + prod_r;
      default: ;
    endcase
    if (cmd.out_load) begin
      out_duty_r  <= duty_nxt;
      out_speed_r <= speed_r;
      out_angle_r <= angle_r;
    end
  end

  assign out_duty  = out_duty_r;
  assign out_speed = out_speed_r;
  assign out_angle = out_angle_r;

  a_duty_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && (floor_r <= ceil_r)) |=>
      (out_duty_r >= $past(floor_r)) && (out_duty_r <= $past(ceil_r)))
    else $error("duty outside floor and ceiling");

endmodule

>>> hw/rtl/motor_speed_pid.sv
// top level of the motor speed pid controller
// input channel: in_valid/in_ready move one word; in_cmd selects a capture
//   (in_capture_time is the free-running timer at an encoder edge) or a
//   control tick. a capture updates period and edge count and gives no result.
// result channel: out_valid/out_ready move one word per control tick with
//   out_duty (per mille), out_speed (rpm, saturated) and out_angle (degrees).
// config port: cfg_wr_en writes cfg_data into register cfg_index;
//   write only while no word is in flight or pending.
// timing: one word at a time. a capture leaves in_ready high, so captures
//   can follow back to back. a tick runs a start step, the restoring
//   divider for the speed, a speed step and an error step, then the pid
//   terms through one 17x33 multiplier and accumulator. the next word can
//   be taken in the same cycle as the result appears.
// stall: a finished result waits in the output registers; new words are
//   accepted meanwhile, and a following tick holds at its output step until
//   the pending word is taken.
// reset: synchronous, active low; config registers go back to defaults and
//   period, edge count, error history and integral clear to zero.
module motor_speed_pid #(
  parameter int SHIFT_BITS     = msp_pkg::SHIFT_BITS_DEF,
  parameter int EDGES_PER_TURN = msp_pkg::EDGES_PER_TURN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [msp_pkg::STAMP_W-1:0]     in_capture_time,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [msp_pkg::DUTY_W-1:0]      out_duty,
  output logic [msp_pkg::SPEED_W-1:0]     out_speed,
  output logic [msp_pkg::ANGLE_W-1:0]     out_angle,
  input  logic                            cfg_wr_en,
  input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  msp_pkg::cmd_t    cmd;
  msp_pkg::status_t st;

  msp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  msp_dp #(
    .SHIFT_BITS     (SHIFT_BITS),
    .EDGES_PER_TURN (EDGES_PER_TURN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_capture_time (in_capture_time),
    .cmd             (cmd),
    .st              (st),
    .out_duty        (out_duty),
    .out_speed       (out_speed),
    .out_angle       (out_angle)
  );

endmodule
